FILE: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("port check failed");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("port check failed");

// Next-cycle implication that also holds through reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("port check failed");

`endif

FILE: rtl/fmip_pkg.sv
package fmip_pkg;

   localparam int CNT_W      = 40;   // occurrence count width
   localparam int OFS_W      = 40;   // letter offset register width
   localparam int CHAR_W     = 8;
   localparam int WORD_W     = 64;
   localparam int BLK_W      = 32;   // characters per block / bitmap width
   localparam int NUM_BLK    = 4;
   localparam int NUM_PLANE  = 12;
   localparam int NUM_LETTER = 4;
   localparam int POS_W      = 7;
   localparam int WIDX_W     = 3;
   localparam int NUM_WORD   = 8;
   localparam int REG_IDX_W  = 2;
   localparam int RSP_USER_W = WIDX_W + 1;
   localparam int SUM_W      = ((CNT_W > OFS_W) ? CNT_W : OFS_W) + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);

   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [OFS_W-1:0]  offset_type;
   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef logic [BLK_W-1:0]  plane_type;
   typedef logic [WIDX_W-1:0] widx_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [QPTR_W-1:0] qptr_type;
   typedef logic [FILL_W-1:0] fill_type;

   typedef enum logic {
      OP_CHAR   = 1'b0,
      OP_FINISH = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      CODE_A = 3'd0,
      CODE_C = 3'd1,
      CODE_G = 3'd2,
      CODE_T = 3'd3,
      CODE_N = 3'd4
   } base_code_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_OFFSET_C = 2'd0,
      REG_OFFSET_G = 2'd1,
      REG_OFFSET_T = 2'd2
   } reg_index_type;

   localparam widx_type WORD_CNT_LO = 3'd0;
   localparam widx_type WORD_CNT_HI = 3'd1;
   localparam widx_type LAST_WORD   = 3'd7;

   // Plane feeding each bitmap slot of the entry (plane = block*3 + bit).
   localparam logic [3:0] SLOT_SRC [NUM_PLANE] = '{
      4'd3, 4'd4, 4'd5, 4'd0, 4'd6, 4'd7, 4'd8, 4'd1, 4'd9, 4'd10, 4'd11, 4'd2
   };

   typedef struct packed {
      offset_type c;
      offset_type g;
      offset_type t;
   } offsets_type;

   // One entry handed from the front to the back. Plane 2 of each block is
   // held already inverted: set for A/C/G/T, clear for N and padding.
   typedef struct packed {
      count_type [NUM_LETTER-1:0] counts;
      logic                       parity;
      plane_type [NUM_PLANE-1:0]  planes;
      logic                       run_end;
   } job_type;

   function automatic base_code_type code_of(input logic [CHAR_W-1:0] ch);
      base_code_type c;
      unique case (ch)
         "A", "a": c = CODE_A;
         "C", "c": c = CODE_C;
         "G", "g": c = CODE_G;
         "T", "t": c = CODE_T;
         default:  c = CODE_N;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/fmip_front.sv
module fmip_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fmip_pkg::CHAR_W-1:0]       req_tdata,   // [7:0] base_char
   input  logic                              req_tuser,   // [0] opcode
   output logic                              push_valid,
   output fmip_pkg::job_type                 push_job,
   input  logic                              push_ready
);

   fmip_pkg::count_type [fmip_pkg::NUM_LETTER-1:0] cnt_ff, cnt_in;
   fmip_pkg::count_type [fmip_pkg::NUM_LETTER-1:0] start_ff, start_in;
   fmip_pkg::plane_type [fmip_pkg::NUM_BLK-1:0]    b0_ff, b0_in, placed0;
   fmip_pkg::plane_type [fmip_pkg::NUM_BLK-1:0]    b1_ff, b1_in, placed1;
   fmip_pkg::plane_type [fmip_pkg::NUM_BLK-1:0]    bv_ff, bv_in, placedv;
   fmip_pkg::plane_type [fmip_pkg::NUM_PLANE-1:0]  job_planes;
   fmip_pkg::pos_type                              pos_ff, pos_in;
   logic                                           parity_ff, parity_in;
   logic                                           pad_pend_ff, pad_pend_in;
   logic                                           accept;
   logic                                           is_fin;
   fmip_pkg::base_code_type                        code;
   logic [1:0]                                     blk;
   logic [4:0]                                     bitpos;

   assign req_tready = !pad_pend_ff && push_ready;

   always_comb begin
      accept = req_tvalid && req_tready;
      is_fin = fmip_pkg::opcode_type'(req_tuser) == fmip_pkg::OP_FINISH;
      code   = fmip_pkg::code_of(req_tdata);
      blk    = pos_ff[6:5];
      bitpos = ~pos_ff[4:0];   // MSB first within a block

      placed0 = b0_ff;
      placed1 = b1_ff;
      placedv = bv_ff;
      if (accept && !is_fin) begin
         placed0[blk][bitpos] = code[0];
         placed1[blk][bitpos] = code[1];
         placedv[blk][bitpos] = (code != fmip_pkg::CODE_N);
      end
      for (int b = 0; b < fmip_pkg::NUM_BLK; b++) begin
         job_planes[b*3]     = placed0[b];
         job_planes[b*3 + 1] = placed1[b];
         job_planes[b*3 + 2] = placedv[b];
      end

      cnt_in      = cnt_ff;
      start_in    = start_ff;
      b0_in       = placed0;
      b1_in       = placed1;
      bv_in       = placedv;
      pos_in      = pos_ff;
      parity_in   = parity_ff;
      pad_pend_in = pad_pend_ff;

      push_valid       = 1'b0;
      push_job.counts  = start_ff;
      push_job.parity  = parity_ff;
      push_job.planes  = job_planes;
      push_job.run_end = 1'b1;

      if (pad_pend_ff) begin
         // second half of a finish: all-padding entry, then clear the stream
         if (push_ready) begin
            push_valid      = 1'b1;
            push_job.planes = '0;
            cnt_in          = '0;
            start_in        = '0;
            b0_in           = '0;
            b1_in           = '0;
            bv_in           = '0;
            pos_in          = '0;
            parity_in       = 1'b0;
            pad_pend_in     = 1'b0;
         end
      end else if (accept && !is_fin) begin
         if (code != fmip_pkg::CODE_N && cnt_ff[code[1:0]] != '1) begin
            cnt_in[code[1:0]] = cnt_ff[code[1:0]] + 1'b1;
         end
         pos_in = pos_ff + 1'b1;
         if (pos_ff == '1) begin
            push_valid = 1'b1;
            start_in   = cnt_in;
            parity_in  = ~parity_ff;
            b0_in      = '0;
            b1_in      = '0;
            bv_in      = '0;
         end
      end else if (accept && is_fin) begin
         push_valid = 1'b1;
         if (pos_ff != '0) begin
            // emit the open entry padded with N, queue the padding entry next
            push_job.run_end = 1'b0;
            start_in         = cnt_ff;
            parity_in        = ~parity_ff;
            b0_in            = '0;
            b1_in            = '0;
            bv_in            = '0;
            pos_in           = '0;
            pad_pend_in      = 1'b1;
         end else begin
            push_job.planes = '0;
            cnt_in          = '0;
            start_in        = '0;
            parity_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         start_ff    <= '0;
         b0_ff       <= '0;
         b1_ff       <= '0;
         bv_ff       <= '0;
         pos_ff      <= '0;
         parity_ff   <= 1'b0;
         pad_pend_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         start_ff    <= start_in;
         b0_ff       <= b0_in;
         b1_ff       <= b1_in;
         bv_ff       <= bv_in;
         pos_ff      <= pos_in;
         parity_ff   <= parity_in;
         pad_pend_ff <= pad_pend_in;
      end
   end

endmodule

FILE: rtl/fmip_queue.sv
module fmip_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  fmip_pkg::job_type push_job,
   output logic              push_ready,
   input  logic              pop,
   output logic              head_valid,
   output fmip_pkg::job_type head_job
);

   fmip_pkg::job_type  mem_ff [fmip_pkg::QUEUE_DEPTH];
   fmip_pkg::qptr_type wr_ptr_ff, wr_ptr_in;
   fmip_pkg::qptr_type rd_ptr_ff, rd_ptr_in;
   fmip_pkg::fill_type fill_ff, fill_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = fill_ff != fmip_pkg::fill_type'(fmip_pkg::QUEUE_DEPTH);
   assign head_valid = fill_ff != '0;
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push_valid && push_ready;
      do_pop    = pop && head_valid;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: rtl/fmip_back.sv
module fmip_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  fmip_pkg::job_type                   head_job,
   output logic                                pop,
   input  fmip_pkg::offsets_type               offsets,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [fmip_pkg::WORD_W-1:0]         rsp_tdata,  // [63:0] word_data
   output logic [fmip_pkg::RSP_USER_W-1:0]     rsp_tuser,  // [2:0] word_index, [3] run_last
   output logic                                rsp_tlast   // entry_last
);

   fmip_pkg::widx_type                            widx_ff, widx_in;
   logic                                          valid_ff, valid_in;
   fmip_pkg::word_type                            data_ff;
   fmip_pkg::widx_type                            idx_ff;
   logic                                          elast_ff;
   logic                                          rlast_ff;
   logic                                          load;
   logic                                          is_last;
   fmip_pkg::count_type                           cnt_sel;
   fmip_pkg::offset_type                          ofs_sel;
   fmip_pkg::sum_type                             sum;
   fmip_pkg::count_type                           sat;
   fmip_pkg::plane_type [fmip_pkg::NUM_PLANE-1:0] slots;
   fmip_pkg::word_type  [fmip_pkg::NUM_WORD-1:0]  pairs;
   fmip_pkg::word_type                            word;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = {rlast_ff, idx_ff};
   assign rsp_tlast  = elast_ff;

   always_comb begin
      load    = head_valid && (!valid_ff || rsp_tready);
      is_last = widx_ff == fmip_pkg::LAST_WORD;
      pop     = load && is_last;
      widx_in = load ? widx_ff + 1'b1 : widx_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end

      // counter words: A,C on even entries, G,T on odd ones
      if (widx_ff == fmip_pkg::WORD_CNT_LO) begin
         cnt_sel = head_job.parity ? head_job.counts[2] : head_job.counts[0];
         ofs_sel = head_job.parity ? offsets.g : '0;
      end else begin
         cnt_sel = head_job.parity ? head_job.counts[3] : head_job.counts[1];
         ofs_sel = head_job.parity ? offsets.t : offsets.c;
      end
      sum = fmip_pkg::sum_type'(cnt_sel) + fmip_pkg::sum_type'(ofs_sel);
      sat = (sum[fmip_pkg::SUM_W-1:fmip_pkg::CNT_W] != '0) ? '1 : sum[fmip_pkg::CNT_W-1:0];

      for (int s = 0; s < fmip_pkg::NUM_PLANE; s++) begin
         slots[s] = head_job.planes[fmip_pkg::SLOT_SRC[s]];
      end
      pairs[0] = '0;
      pairs[1] = '0;
      for (int w = 2; w < fmip_pkg::NUM_WORD; w++) begin
         pairs[w] = {slots[2*w - 3], slots[2*w - 4]};
      end

      if (widx_ff == fmip_pkg::WORD_CNT_LO || widx_ff == fmip_pkg::WORD_CNT_HI) begin
         word = fmip_pkg::word_type'(sat);
      end else begin
         word = pairs[widx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff  <= word;
         idx_ff   <= widx_ff;
         elast_ff <= is_last;
         rlast_ff <= is_last && head_job.run_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         widx_ff  <= widx_in;
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: rtl/fm_index_entry_packer_top.sv
// Throughput: one character per cycle while the entry queue has room; a finish on an open
//   entry holds req_tready low until its padding entry is queued. Entries leave as eight
//   words each from the entry queue, one per cycle while rsp_tready is high.
// Reset (synchronous, active high): clears counts, bitmaps, position, parity, the entry
//   queue, the output register and the offset registers.
module fm_index_entry_packer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [fmip_pkg::CHAR_W-1:0]         req_tdata,  // [7:0] base_char
   input  logic                                req_tuser,  // [0] opcode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [fmip_pkg::WORD_W-1:0]         rsp_tdata,  // [63:0] word_data
   output logic [fmip_pkg::RSP_USER_W-1:0]     rsp_tuser,  // [2:0] word_index, [3] run_last
   output logic                                rsp_tlast,  // entry_last
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fmip_pkg::REG_IDX_W-1:0]      csr_index,
   input  logic [fmip_pkg::OFS_W-1:0]          csr_data
);

   fmip_pkg::offsets_type offs_ff, offs_in;
   fmip_pkg::job_type     push_job;
   fmip_pkg::job_type     head_job;
   logic                  push_valid;
   logic                  push_ready;
   logic                  head_valid;
   logic                  pop;

   assign csr_ready = 1'b1;

   always_comb begin
      offs_in = offs_ff;
      if (csr_valid) begin
         unique case (fmip_pkg::reg_index_type'(csr_index))
            fmip_pkg::REG_OFFSET_C: offs_in.c = csr_data;
            fmip_pkg::REG_OFFSET_G: offs_in.g = csr_data;
            fmip_pkg::REG_OFFSET_T: offs_in.t = csr_data;
            default: ;   // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offs_ff <= '0;
      end else begin
         offs_ff <= offs_in;
      end
   end

   fmip_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   fmip_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   fmip_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .offsets    (offs_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: rtl/fmip_checker.sv
`include "assert_macros.svh"

module fmip_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [fmip_pkg::WORD_W-1:0]         rsp_tdata,
   input logic [fmip_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input logic                                rsp_tlast
);

   logic                                          widx_last;
   logic                                          rsp_rlast;
   logic [fmip_pkg::WORD_W+fmip_pkg::RSP_USER_W:0] rsp_bus;

   assign widx_last = rsp_tuser[fmip_pkg::WIDX_W-1:0] == fmip_pkg::LAST_WORD;
   assign rsp_rlast = rsp_tuser[fmip_pkg::WIDX_W];
   assign rsp_bus   = {rsp_tlast, rsp_tuser, rsp_tdata};

   // entry end only on the last word slot
   `ASSERT_IMPLY(a_last_on_word7, clock, reset, rsp_tvalid && rsp_tlast, widx_last)
   // a run ends only where an entry ends
   `ASSERT_IMPLY(a_run_end_in_entry, clock, reset, rsp_tvalid && rsp_rlast, rsp_tlast)
   // a stalled transaction holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_bus))
   // reset drops the result channel
   `ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_tvalid)

endmodule

bind fm_index_entry_packer_top fmip_checker u_fmip_checker (.*);

FILE: bench/tb_fm_index_entry_packer_top.sv
module tb_fm_index_entry_packer_top;
   import fmip_pkg::*;

   localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam count_type CNT_FULL = '1;
   localparam int PLANE_TO_SLOT [NUM_PLANE] = '{3, 7, 11, 0, 1, 2, 4, 5, 6, 8, 9, 10};
   localparam int PHASE_ITEMS = 20;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 12;

   typedef struct packed {
      opcode_type          op;
      logic [CHAR_W-1:0]   ch;
   } bwt_sym_type;

   typedef struct packed {
      widx_type idx;
      word_type data;
      logic     entry_end;
      logic     run_end;
   } entry_word_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [CHAR_W-1:0]       req_tdata = '0;
   logic                    req_tuser = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [WORD_W-1:0]       rsp_tdata;
   logic [RSP_USER_W-1:0]   rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [REG_IDX_W-1:0]    csr_index = '0;
   logic [OFS_W-1:0]        csr_data = '0;

   fm_index_entry_packer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Prediction model of the packer
   offset_type  ofs_c, ofs_g, ofs_t;
   count_type   letter_cnt [NUM_LETTER];
   count_type   start_cnt [NUM_LETTER];
   plane_type   planes [NUM_PLANE];
   pos_type     char_pos;
   logic        parity;

   bwt_sym_type    bwt_pending [$];
   entry_word_type words_due [$];
   entry_word_type want_word;
   bwt_sym_type    next_sym;

   int  mismatch_count = 0;
   bit  req_taken = 1'b0;
   int  req_gap = 0;
   int  req_burst = 0;
   int  rsp_stall = 0;
   int  rsp_burst = 0;
   bit  sender_steady = 1'b0;
   bit  pressure_req = 1'b0;
   bit  rsp_hold = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic note_mismatch(string what);
      mismatch_count++;
      $display("mismatch: %s", what);
   endtask

   function automatic base_code_type map_base(logic [CHAR_W-1:0] ch);
      // fold lower case onto upper case by clearing bit 5
      case (ch & 8'hDF)
         "A":     return CODE_A;
         "C":     return CODE_C;
         "G":     return CODE_G;
         "T":     return CODE_T;
         default: return CODE_N;
      endcase
   endfunction

   function automatic count_type add_clip(count_type a, offset_type b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, CNT_FULL}) ? CNT_FULL : s[CNT_W-1:0];
   endfunction

   function automatic void clear_stream();
      for (int i = 0; i < NUM_LETTER; i++) begin
         letter_cnt[i] = '0;
         start_cnt[i] = '0;
      end
      for (int i = 0; i < NUM_PLANE; i++) begin
         planes[i] = '0;
      end
      char_pos = '0;
      parity = 1'b0;
   endfunction

   function automatic void drop_bits(base_code_type c);
      logic [2:0] cv;
      int blk;
      int sh;
      cv = c;
      blk = char_pos[6:5];
      sh = 31 - char_pos[4:0];
      for (int p = 0; p < 3; p++) begin
         if (cv[p]) planes[blk*3 + p][sh] = 1'b1;
      end
      char_pos = char_pos + 1'b1;
   endfunction

   function automatic void push_entry();
      count_type      totals [NUM_LETTER];
      plane_type      slot [NUM_PLANE];
      word_type       w [NUM_WORD];
      entry_word_type ew;
      totals[CODE_A] = start_cnt[CODE_A];
      totals[CODE_C] = add_clip(start_cnt[CODE_C], ofs_c);
      totals[CODE_G] = add_clip(start_cnt[CODE_G], ofs_g);
      totals[CODE_T] = add_clip(start_cnt[CODE_T], ofs_t);
      // even entries carry A/C, odd entries G/T
      w[WORD_CNT_LO] = word_type'(totals[parity ? CODE_G : CODE_A]);
      w[WORD_CNT_HI] = word_type'(totals[parity ? CODE_T : CODE_C]);
      for (int i = 0; i < NUM_PLANE; i++) begin
         slot[PLANE_TO_SLOT[i]] = (i % 3 == 2) ? ~planes[i] : planes[i];
      end
      for (int i = 0; i < 6; i++) begin
         w[2 + i] = {slot[2*i + 1], slot[2*i]};
      end
      for (int i = 0; i < NUM_WORD; i++) begin
         ew.idx = widx_type'(i);
         ew.data = w[i];
         ew.entry_end = (widx_type'(i) == LAST_WORD);
         ew.run_end = 1'b0;
         words_due.push_back(ew);
      end
      for (int i = 0; i < NUM_LETTER; i++) begin
         start_cnt[i] = letter_cnt[i];
      end
      parity = ~parity;
      for (int i = 0; i < NUM_PLANE; i++) begin
         planes[i] = '0;
      end
   endfunction

   function automatic void absorb_symbol(bwt_sym_type s);
      int             due_count;
      base_code_type  c;
      entry_word_type tail;
      due_count = words_due.size();
      if (s.op == OP_CHAR) begin
         c = map_base(s.ch);
         if (c != CODE_N && letter_cnt[c] != CNT_FULL) letter_cnt[c] = letter_cnt[c] + 1'b1;
         drop_bits(c);
         if (char_pos == '0) push_entry();
      end else begin
         // pad the open entry with N, then emit the all-padding entry
         if (char_pos != '0) begin
            do drop_bits(CODE_N); while (char_pos != '0);
            push_entry();
         end
         for (int b = 0; b < NUM_BLK; b++) begin
            planes[b*3 + 2] = '1;
         end
         push_entry();
         clear_stream();
      end
      if (words_due.size() > due_count) begin
         tail = words_due.pop_back();
         tail.run_end = 1'b1;
         words_due.push_back(tail);
      end
   endfunction

   function automatic int next_gap();
      int r;
      if (sender_steady) return 0;
      if (req_burst > 0) begin
         req_burst--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         req_burst = $urandom_range(30, 120);
         return 0;
      end
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int next_stall();
      if (rsp_burst > 0) begin
         rsp_burst--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         rsp_burst = $urandom_range(30, 120);
         return 0;
      end
      if ($urandom_range(0, 4) != 0) return 0;
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Sample transactions, predict and check
   always @(posedge clock) begin
      if (!reset) begin
         req_taken = req_tvalid && req_tready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_OFFSET_C: ofs_c = csr_data;
               REG_OFFSET_G: ofs_g = csr_data;
               REG_OFFSET_T: ofs_t = csr_data;
               default: ;
            endcase
         end
         if (req_taken) absorb_symbol(bwt_sym_type'({req_tuser, req_tdata}));
         if (rsp_tvalid && rsp_tready) begin
            if (words_due.size() == 0) begin
               note_mismatch($sformatf("word %0d with nothing pending", rsp_tuser[WIDX_W-1:0]));
            end else begin
               want_word = words_due.pop_front();
               if (rsp_tuser[WIDX_W-1:0] != want_word.idx)
                  note_mismatch($sformatf("word_index %0d, want %0d",
                                          rsp_tuser[WIDX_W-1:0], want_word.idx));
               if (rsp_tdata !== want_word.data)
                  note_mismatch($sformatf("word %0d data %h, want %h",
                                          want_word.idx, rsp_tdata, want_word.data));
               if (rsp_tlast !== want_word.entry_end)
                  note_mismatch($sformatf("word %0d entry_last %b, want %b",
                                          want_word.idx, rsp_tlast, want_word.entry_end));
               if (rsp_tuser[WIDX_W] !== want_word.run_end)
                  note_mismatch($sformatf("word %0d run_last %b, want %b",
                                          want_word.idx, rsp_tuser[WIDX_W], want_word.run_end));
            end
         end
      end
   end

   // Character driver: hold until the transaction completes, then advance
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (bwt_pending.size() != 0) begin
            next_sym = bwt_pending.pop_front();
            req_tdata <= next_sym.ch;
            req_tuser <= next_sym.op;
            req_tvalid <= 1'b1;
            req_gap = next_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Word receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall = next_stall();
         end
      end
   end

   // Long receiver hold-off so the entry queue fills and backs up the input
   initial begin
      wait (pressure_req);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   task automatic write_reg(logic [REG_IDX_W-1:0] idx, offset_type val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CHAR_W-1:0] pick_char();
      logic [CHAR_W-1:0] bases [8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};
      if ($urandom_range(0, 15) < 12) return bases[$urandom_range(0, 7)];
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   function automatic void queue_sym(opcode_type op, logic [CHAR_W-1:0] ch);
      bwt_sym_type s;
      s.op = op;
      s.ch = ch;
      bwt_pending.push_back(s);
   endfunction

   function automatic void queue_run(int n);
      for (int i = 0; i < n; i++) begin
         queue_sym(OP_CHAR, pick_char());
      end
   endfunction

   // Wait until every character is taken and every word has arrived
   task automatic settle();
      int waited;
      waited = 0;
      while ((bwt_pending.size() != 0 || req_tvalid || words_due.size() != 0)
             && waited < 50000) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic offset_type rand_offset();
      return offset_type'({$urandom, $urandom});
   endfunction

   initial begin
      int         budget;
      int         len;
      offset_type base;
      for (int i = 0; i < NUM_LETTER; i++) begin
         letter_cnt[i] = '0;
      end
      ofs_c = '0;
      ofs_g = '0;
      ofs_t = '0;
      clear_stream();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: every letter in both cases, N bytes, finish on empty and open entries
      write_reg(REG_OFFSET_C, 40'd5);
      write_reg(REG_OFFSET_G, 40'd12);
      write_reg(REG_OFFSET_T, 40'd40);
      write_reg(REG_UNUSED, '1);
      queue_sym(OP_FINISH, 8'h00);
      queue_sym(OP_CHAR, "A");
      queue_sym(OP_CHAR, "a");
      queue_sym(OP_CHAR, "C");
      queue_sym(OP_CHAR, "c");
      queue_sym(OP_CHAR, "G");
      queue_sym(OP_CHAR, "g");
      queue_sym(OP_CHAR, "T");
      queue_sym(OP_CHAR, "t");
      queue_sym(OP_CHAR, 8'h00);
      queue_sym(OP_CHAR, 8'hFF);
      queue_sym(OP_CHAR, "N");
      queue_sym(OP_FINISH, 8'hFF);
      queue_sym(OP_FINISH, "A");
      queue_sym(OP_CHAR, "t");
      queue_sym(OP_CHAR, 8'hC1);
      queue_sym(OP_CHAR, "g");
      queue_sym(OP_FINISH, 8'h55);
      settle();

      // pressure: steady sender while the receiver holds off
      write_reg(REG_OFFSET_C, rand_offset());
      write_reg(REG_OFFSET_G, rand_offset());
      write_reg(REG_OFFSET_T, rand_offset());
      sender_steady = 1'b1;
      pressure_req = 1'b1;
      queue_run(260);
      queue_sym(OP_FINISH, pick_char());
      settle();
      sender_steady = 1'b0;

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: base = '1;
            1: base = '0;
            default: base = '1 - offset_type'($urandom_range(0, 300));
         endcase
         write_reg(REG_OFFSET_C, base);
         write_reg(REG_OFFSET_G, base);
         write_reg(REG_OFFSET_T, (ph == 2) ? rand_offset() : base);
         budget = 0;
         while (budget < PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: len = $urandom_range(0, 20);
               5, 6:          len = $urandom_range(21, 100);
               7:             len = 128;
               8:             len = $urandom_range(127, 129);
               default:       len = 0;
            endcase
            queue_run(len);
            queue_sym(OP_FINISH, CHAR_W'($urandom_range(0, 255)));
            budget += len + 1;
         end
         settle();
      end

      if (words_due.size() != 0)
         note_mismatch($sformatf("%0d words never arrived", words_due.size()));
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
